// File: hdl/rsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rsi_pkg;

  localparam int W       = 64;
  localparam int MUL_LAT = 4;
  localparam int DIV_LAT = 65;

  localparam logic signed [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
    return x[W-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic signed [W-1:0] apply_sign(input logic [W-1:0] m, input logic neg);
    logic [W-1:0] v;
    v = (m > SAT_MAX) ? SAT_MAX : m;
    return neg ? -$signed(v) : $signed(v);
  endfunction

  function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] x,
                                               input logic signed [W-1:0] y);
    logic signed [W:0] s;
    s = {x[W-1], x} + {y[W-1], y};
    if (s > $signed({1'b0, SAT_MAX})) return SAT_MAX;
    if (s < -$signed({1'b0, SAT_MAX})) return -SAT_MAX;
    return s[W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: hdl/rsi_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module rsi_mul #(
  parameter int FRAC_BITS = 16
) (
  input  wire                          clk,
  input  wire                          en,
  input  wire logic signed [rsi_pkg::W-1:0] a,
  input  wire logic signed [rsi_pkg::W-1:0] b,
  output logic signed [rsi_pkg::W-1:0]      y
);
  import rsi_pkg::*;

  logic [W-1:0]   ua_r, ub_r;
  logic           ng1_r, ng2_r, ng3_r;
  logic [W-1:0]   ll_r, lh_r, hl_r, hh_r;
  logic [2*W-1:0] prod_r;
  logic [W-1:0]   q;
  logic           over;

  always_comb begin
    q    = prod_r[W+FRAC_BITS-1:FRAC_BITS];
    over = |prod_r[2*W-1:W+FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ua_r   <= mag(a);
      ub_r   <= mag(b);
      ng1_r  <= a[W-1] ^ b[W-1];
      ll_r   <= ua_r[31:0]  * ub_r[31:0];
      lh_r   <= ua_r[31:0]  * ub_r[63:32];
      hl_r   <= ua_r[63:32] * ub_r[31:0];
      hh_r   <= ua_r[63:32] * ub_r[63:32];
      ng2_r  <= ng1_r;
      prod_r <= {64'd0, ll_r} + {32'd0, lh_r, 32'd0} + {32'd0, hl_r, 32'd0} + {hh_r, 64'd0};
      ng3_r  <= ng2_r;
      y      <= apply_sign(over ? {W{1'b1}} : q, ng3_r);
    end
  end

endmodule
`default_nettype wire

// File: hdl/rsi_div.sv
`timescale 1ns / 1ps
`default_nettype none
module rsi_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire                          clk,
  input  wire                          en,
  input  wire logic signed [rsi_pkg::W-1:0] n,
  input  wire logic signed [rsi_pkg::W-1:0] den,
  output logic signed [rsi_pkg::W-1:0]      y
);
  import rsi_pkg::*;

  localparam int QB = W - 1;

  logic [2*W-1:0] num;
  logic [2*W-1:0] lim;
  logic [W-1:0]   ud;

  logic [W-1:0]  rem_r [0:QB];
  logic [QB-1:0] nlo_r [0:QB];
  logic [QB-1:0] q_r   [0:QB];
  logic [W-1:0]  ud_r  [0:QB];
  logic          ov_r  [0:QB];
  logic          ng_r  [0:QB];

  always_comb begin
    ud  = mag(den);
    num = {{W{1'b0}}, mag(n)} << FRAC_BITS;
    lim = {{W{1'b0}}, ud} << QB;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num[2*W-2:QB];
      nlo_r[0] <= num[QB-1:0];
      q_r[0]   <= '0;
      ud_r[0]  <= ud;
      ov_r[0]  <= (num >= lim);
      ng_r[0]  <= n[W-1] ^ den[W-1];
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [W:0] trial;
    logic       take;
    always_comb begin
      trial = {rem_r[k], nlo_r[k][QB-1-k]};
      take  = trial >= {1'b0, ud_r[k]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= take ? (trial[W-1:0] - ud_r[k]) : trial[W-1:0];
        q_r[k+1]   <= q_r[k] | (QB'(take) << (QB-1-k));
        nlo_r[k+1] <= nlo_r[k];
        ud_r[k+1]  <= ud_r[k];
        ov_r[k+1]  <= ov_r[k];
        ng_r[k+1]  <= ng_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y <= apply_sign(ov_r[QB] ? {W{1'b1}} : {1'b0, q_r[QB]}, ng_r[QB]);
    end
  end

endmodule
`default_nettype wire

// File: hdl/ray_sphere_intersection.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | signals                          | content
// in_     | in  | in_tvalid in_tready in_tdata/user | sphere, ray, segment end x
// out_    | out | out_tvalid out_tready tdata/user  | hit distance, hit flags
// One test per clock sustained while the output is not stalled. Two 4-stage multiplier
// banks, a 32-stage square root and 65-stage dividers make up most of the pipeline.
// Synchronous active-low reset clears only valid bits.
// A stall at the output freezes the whole pipeline; in_tready follows it.
module ray_sphere_intersection #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_tvalid,
  output logic                      in_tready,
  // center_x, center_y, center_z, sphere_radius, origin_x, origin_y, origin_z,
  // dir_x, dir_y, dir_z, end_x
  input  wire [((11*COORD_BITS-1+7)/8)*8-1:0] in_tdata,
  // limit_enabled
  input  wire                       in_tuser,
  output logic                      out_tvalid,
  input  wire                       out_tready,
  // hit_distance
  output logic [((COORD_BITS+7)/8)*8-1:0] out_tdata,
  // hit, from_inside
  output logic [1:0]                out_tuser
);
  import rsi_pkg::*;

  localparam int C      = COORD_BITS;
  localparam int OUT_W  = ((C + 7) / 8) * 8;
  localparam int SQ_N   = 32;
  localparam int SQ_K   = (FRAC_BITS + 1) / 2;
  localparam logic signed [W-1:0] HMAX = W'((64'd1 << (C - 1)) - 1);

  typedef logic signed [W-1:0] sw_t;

  typedef struct packed {
    logic vld;
    logic lim;
    logic go;
    sw_t  diff;
    sw_t  d0;
    sw_t  a;
    sw_t  b2;
  } side_t;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  function automatic sw_t sx(input logic [C-1:0] v);
    return {{(W-C){v[C-1]}}, v};
  endfunction

  // stage A
  sw_t   p_r [3];
  sw_t   d_r [3];
  sw_t   r_r;
  side_t sa_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_r.vld <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < 3; k++) begin
        p_r[k] <= sx(in_tdata[(5+k)*C-2 -: C]) - sx(in_tdata[(k+1)*C-1 -: C]);
        d_r[k] <= sx(in_tdata[(7+k)*C-1 +: C]);
      end
      r_r       <= {{(W-C+1){1'b0}}, in_tdata[4*C-2:3*C]};
      sa_r.vld  <= in_tvalid;
      sa_r.lim  <= in_tuser;
      sa_r.go   <= 1'b0;
      sa_r.diff <= sx(in_tdata[11*C-2 -: C]) - sx(in_tdata[5*C-2 -: C]);
      sa_r.d0   <= sx(in_tdata[8*C-2 -: C]);
      sa_r.a    <= '0;
      sa_r.b2   <= '0;
    end
  end

  sw_t dd [3];
  sw_t dp [3];
  sw_t pp [3];
  sw_t rr;

  for (genvar k = 0; k < 3; k++) begin : g_m1
    rsi_mul #(.FRAC_BITS(FRAC_BITS)) u_dd (.clk(clk), .en(en), .a(d_r[k]), .b(d_r[k]), .y(dd[k]));
    rsi_mul #(.FRAC_BITS(FRAC_BITS)) u_dp (.clk(clk), .en(en), .a(d_r[k]), .b(p_r[k]), .y(dp[k]));
    rsi_mul #(.FRAC_BITS(FRAC_BITS)) u_pp (.clk(clk), .en(en), .a(p_r[k]), .b(p_r[k]), .y(pp[k]));
  end
  rsi_mul #(.FRAC_BITS(FRAC_BITS)) u_rr (.clk(clk), .en(en), .a(r_r), .b(r_r), .y(rr));

  side_t s1_r [0:MUL_LAT];
  assign s1_r[0] = sa_r;
  for (genvar k = 0; k < MUL_LAT; k++) begin : g_d1
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s1_r[k+1].vld <= 1'b0;
      end else if (en) begin
        s1_r[k+1] <= s1_r[k];
      end
    end
  end

  // stages B and C
  sw_t   ab_r, bb_r, cb_r, rb_r;
  side_t sb_r;
  sw_t   b2c_r, cc_r;
  side_t sc_r;
  side_t sc_nxt;

  always_comb begin
    sc_nxt   = sb_r;
    sc_nxt.a = ab_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_r.vld <= 1'b0;
      sc_r.vld <= 1'b0;
    end else if (en) begin
      ab_r  <= sadd(sadd(dd[0], dd[1]), dd[2]);
      bb_r  <= sadd(sadd(dp[0], dp[1]), dp[2]);
      cb_r  <= sadd(sadd(pp[0], pp[1]), pp[2]);
      rb_r  <= rr;
      sb_r  <= s1_r[MUL_LAT];
      b2c_r <= sadd(bb_r, bb_r);
      cc_r  <= sadd(cb_r, -rb_r);
      sc_r  <= sc_nxt;
    end
  end

  sw_t ac, bsq;
  rsi_mul #(.FRAC_BITS(FRAC_BITS)) u_ac (.clk(clk), .en(en), .a(sc_r.a), .b(cc_r), .y(ac));
  rsi_mul #(.FRAC_BITS(FRAC_BITS)) u_bb (.clk(clk), .en(en), .a(b2c_r), .b(b2c_r), .y(bsq));

  side_t s2_r [0:MUL_LAT];
  always_comb begin
    s2_r[0]    = sc_r;
    s2_r[0].b2 = b2c_r;
  end
  for (genvar k = 0; k < MUL_LAT; k++) begin : g_d2
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s2_r[k+1].vld <= 1'b0;
      end else if (en) begin
        s2_r[k+1] <= s2_r[k];
      end
    end
  end

  // stages D, E, F
  sw_t         ac4_r, bsq_r, disc_r;
  side_t       sd_r, se_r;
  side_t       sq0_nxt;
  logic [4:0]  sh_nxt;
  logic [W-1:0] x_nxt;

  always_comb begin
    sh_nxt = 5'(SQ_K);
    for (int k = SQ_K; k >= 0; k--) begin
      if ((disc_r >> (2 * k)) < (64'd1 << (W - FRAC_BITS))) sh_nxt = 5'(k);
    end
    x_nxt = (disc_r >> (2 * sh_nxt)) << FRAC_BITS;
  end

  always_comb begin
    sq0_nxt    = se_r;
    sq0_nxt.go = (disc_r > 0) && (se_r.a > 0);
  end

  logic [W-1:0] sqx_r  [0:SQ_N];
  logic [W-1:0] sqr_r  [0:SQ_N];
  logic [4:0]   sqsh_r [0:SQ_N];
  side_t        sqs_r  [0:SQ_N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd_r.vld     <= 1'b0;
      se_r.vld     <= 1'b0;
      sqs_r[0].vld <= 1'b0;
    end else if (en) begin
      ac4_r     <= sadd(sadd(ac, ac), sadd(ac, ac));
      bsq_r     <= bsq;
      sd_r      <= s2_r[MUL_LAT];
      disc_r    <= sadd(bsq_r, -ac4_r);
      se_r      <= sd_r;
      sqx_r[0]  <= x_nxt;
      sqr_r[0]  <= '0;
      sqsh_r[0] <= sh_nxt;
      sqs_r[0]  <= sq0_nxt;
    end
  end

  for (genvar j = 0; j < SQ_N; j++) begin : g_sq
    logic [W-1:0] bt, rb;
    always_comb begin
      bt = 64'd1 << (62 - 2 * j);
      rb = sqr_r[j] + bt;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sqs_r[j+1].vld <= 1'b0;
      end else if (en) begin
        if (sqx_r[j] >= rb) begin
          sqx_r[j+1] <= sqx_r[j] - rb;
          sqr_r[j+1] <= (sqr_r[j] >> 1) + bt;
        end else begin
          sqx_r[j+1] <= sqx_r[j];
          sqr_r[j+1] <= sqr_r[j] >> 1;
        end
        sqsh_r[j+1] <= sqsh_r[j];
        sqs_r[j+1]  <= sqs_r[j];
      end
    end
  end

  // stage G
  sw_t   n1_r, n2_r, a2_r;
  side_t sg_r;
  sw_t   sq;
  assign sq = $signed(sqr_r[SQ_N] << sqsh_r[SQ_N]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sg_r.vld <= 1'b0;
    end else if (en) begin
      n1_r <= sadd(-sqs_r[SQ_N].b2, -sq);
      n2_r <= sadd(-sqs_r[SQ_N].b2, sq);
      a2_r <= sadd(sqs_r[SQ_N].a, sqs_r[SQ_N].a);
      sg_r <= sqs_r[SQ_N];
    end
  end

  sw_t t1, t2, tq;
  rsi_div #(.FRAC_BITS(FRAC_BITS)) u_t1 (.clk(clk), .en(en), .n(n1_r), .den(a2_r), .y(t1));
  rsi_div #(.FRAC_BITS(FRAC_BITS)) u_t2 (.clk(clk), .en(en), .n(n2_r), .den(a2_r), .y(t2));
  rsi_div #(.FRAC_BITS(FRAC_BITS)) u_mx (.clk(clk), .en(en), .n(sg_r.diff), .den(sg_r.d0),
                                         .y(tq));

  side_t s3_r [0:DIV_LAT];
  assign s3_r[0] = sg_r;
  for (genvar k = 0; k < DIV_LAT; k++) begin : g_d3
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s3_r[k+1].vld <= 1'b0;
      end else if (en) begin
        s3_r[k+1] <= s3_r[k];
      end
    end
  end

  // output stage
  side_t sh;
  sw_t   max_t, t_sel;
  logic  ok1, ok2, hit, from_in;

  always_comb begin
    sh      = s3_r[DIV_LAT];
    max_t   = (sh.d0 <= 0) ? sh.diff : tq;
    ok1     = (t1 > 0) && (!sh.lim || t1 < max_t);
    ok2     = (t2 > 0) && (!sh.lim || t2 < max_t);
    hit     = sh.go && (ok1 || ok2);
    from_in = sh.go && !ok1 && ok2;
    t_sel   = ok1 ? t1 : t2;
    if (!hit) t_sel = -(sw_t'(1) <<< FRAC_BITS);
    else if (t_sel > HMAX) t_sel = HMAX;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (en) begin
      out_tvalid <= sh.vld;
      out_tdata  <= OUT_W'(t_sel[C-1:0]);
      out_tuser  <= {from_in, hit};
    end
  end

endmodule
`default_nettype wire
